// ===== design/per_flow_join_flood_detector_assert.svh =====
// Assertion macros shared by the flood detector RTL.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef PER_FLOW_JOIN_FLOOD_DETECTOR_ASSERT_SVH
`define PER_FLOW_JOIN_FLOOD_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define PFJFD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define PFJFD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/pfjfd_pkg.sv =====
// Package for the per-flow join flood detector: sizes, codes and shared types.
// No dependencies; every other design file but the assertion macro header imports it.
`default_nettype none

package pfjfd_pkg;

   // Table and field sizes
   localparam int TABLE_DEPTH   = 64;  // power of two
   localparam int IDX_BITS      = $clog2(TABLE_DEPTH);
   localparam int TIME_BITS     = 32;
   localparam int CHAN_BITS     = 6;
   localparam int NOW_BITS      = 32;
   localparam int COUNT_BITS    = 16;
   localparam int THR_BITS      = 16;
   localparam int SEC_BITS      = 17;
   localparam int CSR_DATA_BITS = 17;
   localparam int CSR_IDX_BITS  = 2;

   // Request queue between front and back (power of two)
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Register reset values
   localparam logic [THR_BITS-1:0] RST_THRESHOLD = THR_BITS'(10);
   localparam logic [SEC_BITS-1:0] RST_WINDOW    = SEC_BITS'(5);
   localparam logic [SEC_BITS-1:0] RST_HOLD      = SEC_BITS'(120);

   typedef enum logic [0:0] {
      ACT_JOIN  = 1'b0,
      ACT_CHECK = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_FLOOD   = 2'd1,
      EV_RELEASE = 2'd2,
      EV_FREED   = 2'd3
   } event_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ACTIVE    = 2'd0,
      CSR_THRESHOLD = 2'd1,
      CSR_WINDOW    = 2'd2,
      CSR_HOLD      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                active;
      logic [THR_BITS-1:0] threshold;
      logic [SEC_BITS-1:0] window;
      logic [SEC_BITS-1:0] hold;
   } cfg_type;

   // Classified request as it sits in the queue
   typedef struct packed {
      action_type           action;
      logic [IDX_BITS-1:0]  idx;
      logic [CHAN_BITS-1:0] channel;
      logic [TIME_BITS-1:0] now;
   } item_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

   // One table entry
   typedef struct packed {
      logic [TIME_BITS-1:0]  window_end;
      logic [COUNT_BITS-1:0] joins;
      logic                  flood;
      logic [TIME_BITS-1:0]  release_time;
   } entry_type;

endpackage

`default_nettype wire

// ===== design/pfjfd_if.sv =====
// Valid/ready channel interfaces for requests and responses of the flood detector.
// Depends on pfjfd_pkg for field widths.
`default_nettype none

interface pfjfd_req_if import pfjfd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 action;
   logic [CHAN_BITS-1:0] channel;
   logic [NOW_BITS-1:0]  now_seconds;

   modport source (output valid, action, channel, now_seconds, input ready);
   modport sink   (input valid, action, channel, now_seconds, output ready);
endinterface

interface pfjfd_rsp_if import pfjfd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            event_res;
   logic [CHAN_BITS-1:0]  channel_out;
   logic [COUNT_BITS-1:0] join_count;

   modport source (output valid, event_res, channel_out, join_count, input ready);
   modport sink   (input valid, event_res, channel_out, join_count, output ready);
endinterface

`default_nettype wire

// ===== design/per_flow_join_flood_detector.sv =====
// Per-channel join flood detector. Each request is a join or a check on one of
// TABLE_DEPTH channel entries and yields exactly one response, in request order.
// Requests enter a four-deep queue; the back end then takes each in two steps
// (table read, then update and response load, which waits for a free response
// slot) and reads no new request from the queue until the last one is loaded.
// Entry valid bits clear at reset, so no clearing pass is needed. Configuration
// writes (csr_we, csr_index, csr_wdata) take effect at the next edge; the user
// must make them only while the block is idle, as the block does not enforce it.
// Depends on pfjfd_pkg, pfjfd_if, pfjfd_front and pfjfd_back.
`default_nettype none

module per_flow_join_flood_detector import pfjfd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   pfjfd_req_if.sink                req_ch,
   pfjfd_rsp_if.source              rsp_ch,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cfg_type       cfg_ff, cfg_in;
   queue_out_type q_head;
   logic          q_pop;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ACTIVE:    cfg_in.active    = csr_wdata[0];
            CSR_THRESHOLD: cfg_in.threshold = csr_wdata[THR_BITS-1:0];
            CSR_WINDOW:    cfg_in.window    = csr_wdata[SEC_BITS-1:0];
            CSR_HOLD:      cfg_in.hold      = csr_wdata[SEC_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active    <= 1'b0;
         cfg_ff.threshold <= RST_THRESHOLD;
         cfg_ff.window    <= RST_WINDOW;
         cfg_ff.hold      <= RST_HOLD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pfjfd_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .q_out (q_head),
      .q_pop (q_pop)
   );

   pfjfd_back u_back (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .q_in  (q_head),
      .q_pop (q_pop),
      .rsp   (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== design/pfjfd_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on pfjfd_pkg, pfjfd_req_if and the assertion macro header.
`default_nettype none
`include "per_flow_join_flood_detector_assert.svh"

module pfjfd_front import pfjfd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   pfjfd_req_if.sink     req,
   output queue_out_type q_out,
   input  logic          q_pop
);

   item_type                 fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_PTR_BITS:0]   count_ff, count_in;
   item_type                 in_item;
   logic                     push;

   // Classify the incoming request
   always_comb begin
      in_item.action  = action_type'(req.action);
      in_item.idx     = IDX_BITS'(req.channel);
      in_item.channel = req.channel;
      in_item.now     = TIME_BITS'(req.now_seconds);
   end

   assign req.ready = (count_ff != (FIFO_PTR_BITS+1)'(FIFO_DEPTH));
   assign push      = req.valid && req.ready;

   assign q_out.valid = (count_ff != '0);
   assign q_out.item  = fifo_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= in_item;
      end
   end

   `PFJFD_ASSERT_NOW(a_fill_bound, 1'b1, count_ff <= (FIFO_PTR_BITS+1)'(FIFO_DEPTH), "queue overfilled")
   `PFJFD_ASSERT_NOW(a_no_pop_empty, q_pop, count_ff != '0, "pop from empty queue")
   `PFJFD_ASSERT_NEXT(a_drain, q_pop && !push, count_ff == $past(count_ff) - 1'b1, "fill count off after pop")

endmodule

`default_nettype wire

// ===== design/pfjfd_back.sv =====
// Back end: channel table read-modify-write and the response register.
// Depends on pfjfd_pkg, pfjfd_rsp_if and the assertion macro header.
`default_nettype none
`include "per_flow_join_flood_detector_assert.svh"

module pfjfd_back import pfjfd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  queue_out_type q_in,
   output logic          q_pop,
   pfjfd_rsp_if.source   rsp
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   entry_type             table_mem [TABLE_DEPTH];
   entry_type             rd_data_ff;
   item_type              cur_ff;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   event_type             rsp_event_ff;
   logic [CHAN_BITS-1:0]  rsp_chan_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff;

   logic                  go;
   logic                  load;
   logic                  hit;
   logic [TIME_BITS-1:0]  win_end_new;
   logic [TIME_BITS-1:0]  hold_end;
   logic [COUNT_BITS-1:0] cnt_inc;
   logic                  wr_en;
   entry_type             wr_entry;
   logic                  valid_set;
   logic                  valid_clr;
   event_type             ev;
   logic [COUNT_BITS-1:0] cnt_out;

   // Sequencer: read the entry, then update it once the response slot is free
   assign go    = !rsp_valid_ff || rsp.ready;
   assign q_pop = (state_ff == S_IDLE) && q_in.valid;
   assign load  = (state_ff == S_EXEC) && go;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (q_in.valid) state_in = S_EXEC;
         S_EXEC: if (go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Window, hold and count arithmetic
   assign hit         = valid_ff[cur_ff.idx];
   assign win_end_new = cur_ff.now + TIME_BITS'(cfg.window);
   assign hold_end    = cur_ff.now + TIME_BITS'(cfg.hold);
   assign cnt_inc     = (rd_data_ff.joins == COUNT_MAX) ? rd_data_ff.joins
                                                        : rd_data_ff.joins + 1'b1;

   // Entry update and event decision
   always_comb begin
      wr_en     = 1'b0;
      wr_entry  = rd_data_ff;
      valid_set = 1'b0;
      valid_clr = 1'b0;
      ev        = EV_NONE;
      cnt_out   = '0;
      case (cur_ff.action)
         ACT_JOIN: begin
            if (cfg.active) begin
               if (!hit) begin
                  wr_en                 = 1'b1;
                  valid_set             = 1'b1;
                  wr_entry.window_end   = win_end_new;
                  wr_entry.release_time = win_end_new;
                  wr_entry.joins        = COUNT_BITS'(1);
                  wr_entry.flood        = 1'b0;
               end else if (!rd_data_ff.flood) begin
                  wr_en = 1'b1;
                  if (cur_ff.now >= rd_data_ff.window_end) begin
                     // window over: restart it
                     wr_entry.window_end   = win_end_new;
                     wr_entry.release_time = win_end_new;
                     wr_entry.joins        = COUNT_BITS'(1);
                  end else begin
                     wr_entry.joins = cnt_inc;
                     if (cnt_inc >= cfg.threshold) begin
                        wr_entry.flood        = 1'b1;
                        wr_entry.release_time = hold_end;
                        ev                    = EV_FLOOD;
                        cnt_out               = cnt_inc;
                     end
                  end
               end
            end
         end
         ACT_CHECK: begin
            // release a flood past its hold, or free an idle entry past its window
            if (hit && (cur_ff.now > rd_data_ff.release_time)) begin
               valid_clr = 1'b1;
               ev        = rd_data_ff.flood ? EV_RELEASE : EV_FREED;
            end
         end
         default: ;
      endcase
   end

   // Entry valid bits
   always_comb begin
      valid_in = valid_ff;
      if (load && valid_set) valid_in[cur_ff.idx] = 1'b1;
      if (load && valid_clr) valid_in[cur_ff.idx] = 1'b0;
   end

   assign rsp_valid_in = load || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Captured request and response payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_in.item;
      end
      if (load) begin
         rsp_event_ff <= ev;
         rsp_chan_ff  <= cur_ff.channel;
         rsp_count_ff <= cnt_out;
      end
   end

   // Channel table
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_data_ff <= table_mem[q_in.item.idx];
      end
      if (load && wr_en) begin
         table_mem[cur_ff.idx] <= wr_entry;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.event_res   = rsp_event_ff;
   assign rsp.channel_out = rsp_chan_ff;
   assign rsp.join_count  = rsp_count_ff;

   `PFJFD_ASSERT_NOW(a_flood_count, rsp_valid_ff && rsp_event_ff == EV_FLOOD, rsp_count_ff != '0, "flood reported with zero count")
   `PFJFD_ASSERT_NOW(a_other_count, rsp_valid_ff && rsp_event_ff != EV_FLOOD, rsp_count_ff == '0, "count on non-flood event")
   `PFJFD_ASSERT_NEXT(a_clear_entry, load && valid_clr, !valid_ff[$past(cur_ff.idx)], "entry still valid after release")
   `PFJFD_ASSERT_NEXT(a_set_entry, load && valid_set, valid_ff[$past(cur_ff.idx)], "entry not valid after creation")

endmodule

`default_nettype wire
